// ===== src/skc_pkg.sv =====
// shared types, constants and the kill duration table for the shift kill controller
// no dependencies
`default_nettype none

package skc_pkg;

    localparam int unsigned SENSOR_W   = 8;
    localparam int unsigned RPM_W      = 16;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned PRESS_W    = 8;
    localparam int unsigned DUR_W      = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SENSOR_W-1:0] SENSOR_PRESS_MAX = 8'h40;
    localparam logic [SENSOR_W-1:0] SENSOR_SIXTH_MIN = 8'hF0;
    localparam logic [SENSOR_W-1:0] SENSOR_LOW_GEAR  = 8'hAA;
    localparam logic [SENSOR_W-1:0] SENSOR_HIGH_GEAR = 8'hF8;
    localparam logic [RPM_W-1:0]    RPM_PRESS_MIN    = 16'h1400;
    localparam int unsigned         DUR_RPM_BASE     = 32'h1E00;
    localparam int unsigned         DUR_RPM_STEP     = 32'h0A00;
    localparam int unsigned         DUR_BINS         = 10;

    localparam logic [COUNT_W-1:0] REARM_DELAY_RST      = 16'd400;
    localparam logic [PRESS_W-1:0] MIN_ACTIVE_COUNT_RST = 8'd5;
    localparam logic [RPM_W-1:0]   LOW_GEAR_RPM_RST     = 16'd20480;
    localparam logic [RPM_W-1:0]   HIGH_GEAR_RPM_RST    = 16'd25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REARM_DELAY      = 3'd0,
        REG_MIN_ACTIVE_COUNT = 3'd1,
        REG_LOW_GEAR_RPM     = 3'd2,
        REG_HIGH_GEAR_RPM    = 3'd3,
        REG_IGN_CUT_ENABLE   = 3'd4,
        REG_FUEL_CUT_ENABLE  = 3'd5,
        REG_PAIR_RPM_MODE    = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        PAIR_LEAVE = 2'd0,
        PAIR_CLEAR = 2'd1,
        PAIR_SET   = 2'd2
    } pair_action_t;

    typedef struct packed {
        logic [COUNT_W-1:0] rearm_delay;
        logic [PRESS_W-1:0] min_active_count;
        logic [RPM_W-1:0]   low_gear_rpm;
        logic [RPM_W-1:0]   high_gear_rpm;
        logic               ign_cut_enable;
        logic               fuel_cut_enable;
        logic               pair_rpm_mode;
    } cfg_t;

    typedef struct packed {
        logic         fuel_cut;
        logic         ign_cut;
        pair_action_t pair_action;
        logic         kill_on;
    } result_t;

    function automatic logic [DUR_W-1:0] dur_entry(input logic [3:0] idx);
        logic [DUR_W-1:0] d;
        case (idx)
            4'd0:    d = 9'h03E;
            4'd1:    d = 9'h05D;
            4'd2:    d = 9'h07C;
            4'd3:    d = 9'h09C;
            4'd4:    d = 9'h0BB;
            4'd5:    d = 9'h0DA;
            4'd6:    d = 9'h0F9;
            4'd7:    d = 9'h119;
            4'd8:    d = 9'h138;
            4'd9:    d = 9'h158;
            4'd10:   d = 9'h177;
            default: d = 9'h03E;
        endcase
        return d;
    endfunction

    // rpm bins are monotone, so the highest exceeded threshold wins
    function automatic logic [DUR_W-1:0] pick_duration(input logic [RPM_W-1:0] rpm);
        logic [3:0]       idx;
        logic [RPM_W-1:0] thr;
        idx = 4'd0;
        for (int k = 0; k < DUR_BINS; k++) begin
            thr = RPM_W'(DUR_RPM_BASE + k * DUR_RPM_STEP);
            if (rpm > thr) begin
                idx = 4'(k + 1);
            end
        end
        return dur_entry(idx);
    endfunction

endpackage

`default_nettype wire

// ===== src/skc_cfg_regs.sv =====
// configuration register file for the shift kill controller
// depends on skc_pkg
`default_nettype none

module skc_cfg_regs
    import skc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_REARM_DELAY:      cfg_next.rearm_delay      = cfg_wdata;
                REG_MIN_ACTIVE_COUNT: cfg_next.min_active_count = cfg_wdata[PRESS_W-1:0];
                REG_LOW_GEAR_RPM:     cfg_next.low_gear_rpm     = cfg_wdata;
                REG_HIGH_GEAR_RPM:    cfg_next.high_gear_rpm    = cfg_wdata;
                REG_IGN_CUT_ENABLE:   cfg_next.ign_cut_enable   = cfg_wdata[0];
                REG_FUEL_CUT_ENABLE:  cfg_next.fuel_cut_enable  = cfg_wdata[0];
                REG_PAIR_RPM_MODE:    cfg_next.pair_rpm_mode    = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rearm_delay      <= REARM_DELAY_RST;
            cfg_reg.min_active_count <= MIN_ACTIVE_COUNT_RST;
            cfg_reg.low_gear_rpm     <= LOW_GEAR_RPM_RST;
            cfg_reg.high_gear_rpm    <= HIGH_GEAR_RPM_RST;
            cfg_reg.ign_cut_enable   <= 1'b1;
            cfg_reg.fuel_cut_enable  <= 1'b1;
            cfg_reg.pair_rpm_mode    <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/skc_core.sv =====
// per-tick kill state update and result logic for the shift kill controller
// depends on skc_pkg
`default_nettype none

module skc_core
    import skc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire logic [SENSOR_W-1:0] sensor_level,
    input  wire logic [RPM_W-1:0]    engine_rpm,
    input  wire cfg_t                cfg,
    output result_t                  result
);

    logic               started_reg;
    logic               kill_state_reg,      kill_state_next;
    logic               switch_pressed_reg,  switch_pressed_next;
    logic [PRESS_W-1:0] press_count_reg,     press_count_next;
    logic [COUNT_W-1:0] kill_counter_reg,    kill_counter_next;
    logic [DUR_W-1:0]   kill_duration_reg,   kill_duration_next;
    logic               sixth_gear_flag_reg, sixth_gear_flag_next;
    logic [COUNT_W-1:0] sixth_gear_hold_reg, sixth_gear_hold_next;
    logic [COUNT_W-1:0] kc_inc;
    pair_action_t       pair;

    always_comb begin
        // first tick after reset clears the kill and press state and loads both counters from the rearm delay
        kill_state_next      = started_reg ? kill_state_reg : 1'b0;
        switch_pressed_next  = started_reg ? switch_pressed_reg : 1'b0;
        press_count_next     = started_reg ? press_count_reg : '0;
        kill_counter_next    = started_reg ? kill_counter_reg : cfg.rearm_delay;
        sixth_gear_hold_next = started_reg ? sixth_gear_hold_reg : cfg.rearm_delay;
        sixth_gear_flag_next = sixth_gear_flag_reg;
        kill_duration_next   = kill_duration_reg;
        kc_inc               = kill_counter_next + 16'd1;

        if (sensor_level <= SENSOR_PRESS_MAX) begin
            if (!sixth_gear_flag_reg && engine_rpm > RPM_PRESS_MIN) begin
                switch_pressed_next = 1'b1;
                kill_duration_next  = pick_duration(engine_rpm);
            end
        end else begin
            switch_pressed_next = 1'b0;
            if (sensor_level >= SENSOR_SIXTH_MIN) begin
                sixth_gear_flag_next = 1'b1;
                sixth_gear_hold_next = cfg.rearm_delay;
            end else if (sixth_gear_hold_next == '0) begin
                sixth_gear_flag_next = 1'b0;
            end else begin
                sixth_gear_hold_next = sixth_gear_hold_next - 16'd1;
            end
        end

        if (kill_state_next) begin
            kill_counter_next = kc_inc;
            if (kc_inc >= {{(COUNT_W-DUR_W){1'b0}}, kill_duration_next}) begin
                kill_state_next   = 1'b0;
                kill_counter_next = cfg.rearm_delay;
            end
        end else if (kill_counter_next != '0) begin
            // rearm delay only runs while released
            if (!switch_pressed_next) begin
                kill_counter_next = kill_counter_next - 16'd1;
            end
        end else if (switch_pressed_next) begin
            if (press_count_next != '1) begin
                press_count_next = press_count_next + 8'd1;
            end
            if (press_count_next >= cfg.min_active_count) begin
                kill_state_next   = 1'b1;
                kill_counter_next = '0;
            end
        end else begin
            press_count_next = '0;
        end

        if (!cfg.pair_rpm_mode) begin
            pair = PAIR_LEAVE;
        end else if ((sensor_level < SENSOR_LOW_GEAR && cfg.low_gear_rpm < engine_rpm) ||
                     (sensor_level < SENSOR_HIGH_GEAR && cfg.high_gear_rpm < engine_rpm)) begin
            pair = PAIR_CLEAR;
        end else begin
            pair = PAIR_SET;
        end

        result.fuel_cut    = kill_state_next & cfg.fuel_cut_enable;
        result.ign_cut     = kill_state_next & cfg.ign_cut_enable;
        result.pair_action = pair;
        result.kill_on     = kill_state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg         <= 1'b0;
            kill_state_reg      <= 1'b0;
            switch_pressed_reg  <= 1'b0;
            press_count_reg     <= '0;
            kill_counter_reg    <= '0;
            kill_duration_reg   <= '0;
            sixth_gear_flag_reg <= 1'b0;
            sixth_gear_hold_reg <= '0;
        end else if (step_en) begin
            started_reg         <= 1'b1;
            kill_state_reg      <= kill_state_next;
            switch_pressed_reg  <= switch_pressed_next;
            press_count_reg     <= press_count_next;
            kill_counter_reg    <= kill_counter_next;
            kill_duration_reg   <= kill_duration_next;
            sixth_gear_flag_reg <= sixth_gear_flag_next;
            sixth_gear_hold_reg <= sixth_gear_hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/shift_kill_controller_unit.sv =====
// path: input register, combinational kill state update, result register
// throughput: one tick per cycle while the result side does not stall (m_ready)
// reset: synchronous active-low aresetn clears the valid flags of both register stages and
// the kill state, and restores the configuration registers to their defaults
// top level of the shift kill controller; depends on skc_pkg, skc_cfg_regs, skc_core
`default_nettype none

module shift_kill_controller_unit
    import skc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [SENSOR_W-1:0]   s_sensor_level,
    input  wire logic [RPM_W-1:0]      s_engine_rpm,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_fuel_cut,
    output logic                       m_ign_cut,
    output logic [1:0]                 m_pair_action,
    output logic                       m_kill_on,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                cfg;
    result_t             step_result;
    result_t             out_res_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic [SENSOR_W-1:0] in_sensor_reg;
    logic [RPM_W-1:0]    in_rpm_reg;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    skc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    skc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .sensor_level (in_sensor_reg),
        .engine_rpm   (in_rpm_reg),
        .cfg          (cfg),
        .result       (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sensor_reg <= s_sensor_level;
            in_rpm_reg    <= s_engine_rpm;
        end
        if (advance) begin
            out_res_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_fuel_cut    = out_res_reg.fuel_cut;
    assign m_ign_cut     = out_res_reg.ign_cut;
    assign m_pair_action = out_res_reg.pair_action;
    assign m_kill_on     = out_res_reg.kill_on;

endmodule

`default_nettype wire

// ===== src/skc_checker.sv =====
// port-level checks for shift_kill_controller_unit, bound to the top level
// depends on skc_pkg
`default_nettype none

module skc_checker
    import skc_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_fuel_cut,
    input wire logic       m_ign_cut,
    input wire logic [1:0] m_pair_action,
    input wire logic       m_kill_on
);

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fuel_cut) && $stable(m_ign_cut)
            && $stable(m_pair_action) && $stable(m_kill_on))
        else $error("result changed while stalled");

    // cut requests only while the kill is on
    a_cut_needs_kill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_fuel_cut || m_ign_cut) |-> m_kill_on)
        else $error("cut request without kill");

    a_pair_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pair_action != 2'd3)
        else $error("invalid pair action code");

    // every input transfer must be followed by a valid result
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("result missing after input transfer");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind shift_kill_controller_unit skc_checker u_skc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_fuel_cut    (m_fuel_cut),
    .m_ign_cut     (m_ign_cut),
    .m_pair_action (m_pair_action),
    .m_kill_on     (m_kill_on)
);

`default_nettype wire

// ===== sim/shift_kill_controller_unit_tb.sv =====
// self-checking testbench for shift_kill_controller_unit: fuel-loop ticks with random gaps and
// result back-pressure, checked against a cycle-free predictor of the kill and PAIR logic
// depends on skc_pkg and the shift_kill_controller_unit rtl
`timescale 1ns / 1ps

module shift_kill_controller_unit_tb
    import skc_pkg::*;
;

    // predicts the cut and PAIR outputs of each tick and holds them until they come out
    class kill_tracker;
        cfg_t             settings;
        logic             started;
        logic             kill_active;
        logic             pressed;
        logic             sixth_flag;
        logic [PRESS_W-1:0] press_cnt;
        logic [COUNT_W-1:0] kill_cnt;
        logic [COUNT_W-1:0] sixth_hold;
        logic [DUR_W-1:0]   duration;
        logic [DUR_W-1:0]   kill_ticks[11];
        result_t          due_outputs[$];
        int unsigned      n_ticks;
        int unsigned      n_checked;
        int unsigned      n_kills;
        int unsigned      n_errors;

        function new();
            settings.rearm_delay      = REARM_DELAY_RST;
            settings.min_active_count = MIN_ACTIVE_COUNT_RST;
            settings.low_gear_rpm     = LOW_GEAR_RPM_RST;
            settings.high_gear_rpm    = HIGH_GEAR_RPM_RST;
            settings.ign_cut_enable   = 1'b1;
            settings.fuel_cut_enable  = 1'b1;
            settings.pair_rpm_mode    = 1'b1;
            started     = 1'b0;
            kill_active = 1'b0;
            pressed     = 1'b0;
            sixth_flag  = 1'b0;
            press_cnt   = '0;
            kill_cnt    = '0;
            sixth_hold  = '0;
            duration    = '0;
            kill_ticks  = '{9'h03E, 9'h05D, 9'h07C, 9'h09C, 9'h0BB, 9'h0DA,
                            9'h0F9, 9'h119, 9'h138, 9'h158, 9'h177};
            n_ticks   = 0;
            n_checked = 0;
            n_kills   = 0;
            n_errors  = 0;
        endfunction

        function void write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_REARM_DELAY:      settings.rearm_delay      = val;
                REG_MIN_ACTIVE_COUNT: settings.min_active_count = val[PRESS_W-1:0];
                REG_LOW_GEAR_RPM:     settings.low_gear_rpm     = val;
                REG_HIGH_GEAR_RPM:    settings.high_gear_rpm    = val;
                REG_IGN_CUT_ENABLE:   settings.ign_cut_enable   = val[0];
                REG_FUEL_CUT_ENABLE:  settings.fuel_cut_enable  = val[0];
                REG_PAIR_RPM_MODE:    settings.pair_rpm_mode    = val[0];
                default: ;
            endcase
        endfunction

        function logic [DUR_W-1:0] duration_for(input logic [RPM_W-1:0] rpm);
            int bin;
            bin = 0;
            for (int k = 0; k < 10; k++) begin
                if (int'(rpm) > DUR_RPM_BASE + k * DUR_RPM_STEP) begin
                    bin = k + 1;
                end
            end
            return kill_ticks[bin];
        endfunction

        function void note_tick(input logic [SENSOR_W-1:0] sensor, input logic [RPM_W-1:0] rpm);
            result_t res;
            // the first tick after reset loads both counters from the rearm delay
            if (!started) begin
                kill_active = 1'b0;
                pressed     = 1'b0;
                press_cnt   = '0;
                started     = 1'b1;
                sixth_hold  = settings.rearm_delay;
                kill_cnt    = settings.rearm_delay;
            end
            if (sensor <= SENSOR_PRESS_MAX) begin
                // a blocked press keeps the old switch state and duration
                if (!sixth_flag && rpm > RPM_PRESS_MIN) begin
                    pressed  = 1'b1;
                    duration = duration_for(rpm);
                end
            end else begin
                pressed = 1'b0;
                if (sensor >= SENSOR_SIXTH_MIN) begin
                    sixth_flag = 1'b1;
                    sixth_hold = settings.rearm_delay;
                end else if (sixth_hold == '0) begin
                    sixth_flag = 1'b0;
                end else begin
                    sixth_hold = sixth_hold - 1'b1;
                end
            end
            if (kill_active) begin
                kill_cnt = kill_cnt + 1'b1;
                if (kill_cnt >= duration) begin
                    kill_active = 1'b0;
                    kill_cnt    = settings.rearm_delay;
                end
            end else if (kill_cnt != '0) begin
                if (!pressed) begin
                    kill_cnt = kill_cnt - 1'b1;
                end
            end else if (pressed) begin
                if (press_cnt != 8'hFF) begin
                    press_cnt = press_cnt + 1'b1;
                end
                if (press_cnt >= settings.min_active_count) begin
                    kill_active = 1'b1;
                    kill_cnt    = '0;
                    n_kills++;
                end
            end else begin
                press_cnt = '0;
            end
            if (!settings.pair_rpm_mode) begin
                res.pair_action = PAIR_LEAVE;
            end else if (sensor < SENSOR_LOW_GEAR && settings.low_gear_rpm < rpm) begin
                res.pair_action = PAIR_CLEAR;
            end else if (sensor < SENSOR_HIGH_GEAR && settings.high_gear_rpm < rpm) begin
                res.pair_action = PAIR_CLEAR;
            end else begin
                res.pair_action = PAIR_SET;
            end
            res.fuel_cut = kill_active && settings.fuel_cut_enable;
            res.ign_cut  = kill_active && settings.ign_cut_enable;
            res.kill_on  = kill_active;
            due_outputs.push_back(res);
            n_ticks++;
        endfunction

        function void check_output(input result_t got);
            result_t want;
            if (due_outputs.size() == 0) begin
                $display("%0t: result transfer with no tick pending", $time);
                n_errors++;
                return;
            end
            want = due_outputs.pop_front();
            n_checked++;
            if (got.fuel_cut !== want.fuel_cut) begin
                $display("%0t: fuel_cut expected %0b actual %0b", $time,
                         want.fuel_cut, got.fuel_cut);
                n_errors++;
            end
            if (got.ign_cut !== want.ign_cut) begin
                $display("%0t: ign_cut expected %0b actual %0b", $time,
                         want.ign_cut, got.ign_cut);
                n_errors++;
            end
            if (got.pair_action !== want.pair_action) begin
                $display("%0t: pair_action expected %0d actual %0d", $time,
                         want.pair_action, got.pair_action);
                n_errors++;
            end
            if (got.kill_on !== want.kill_on) begin
                $display("%0t: kill_on expected %0b actual %0b", $time,
                         want.kill_on, got.kill_on);
                n_errors++;
            end
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction
    endclass

    localparam int N_DIRECTED = 14;
    localparam logic [SENSOR_W-1:0] DIR_SENSOR [N_DIRECTED] = '{
        8'h00, 8'h40, 8'h40, 8'h41, 8'hA9, 8'hAA, 8'hAA,
        8'hF7, 8'hF8, 8'h20, 8'hFF, 8'h55, 8'hAA, 8'h80
    };
    localparam logic [RPM_W-1:0] DIR_RPM [N_DIRECTED] = '{
        16'hFFFF, 16'h1401, 16'h1400, 16'h0000, 16'h5001, 16'h5001, 16'h6401,
        16'h6401, 16'hFFFF, 16'h7FFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h8000
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [SENSOR_W-1:0]   s_sensor_level;
    logic [RPM_W-1:0]      s_engine_rpm;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_fuel_cut;
    logic                  m_ign_cut;
    logic [1:0]            m_pair_action;
    logic                  m_kill_on;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    kill_tracker tracker;
    bit          quiet_gaps = 1'b0;
    int unsigned n_settings = 1;

    shift_kill_controller_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_level (s_sensor_level),
        .s_engine_rpm   (s_engine_rpm),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fuel_cut     (m_fuel_cut),
        .m_ign_cut      (m_ign_cut),
        .m_pair_action  (m_pair_action),
        .m_kill_on      (m_kill_on),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic cfg_t make_settings(input logic [15:0] rearm, input logic [7:0] min_cnt,
                                           input logic [15:0] low_rpm, input logic [15:0] high_rpm,
                                           input logic ign, input logic fuel, input logic pair);
        cfg_t c;
        c.rearm_delay      = rearm;
        c.min_active_count = min_cnt;
        c.low_gear_rpm     = low_rpm;
        c.high_gear_rpm    = high_rpm;
        c.ign_cut_enable   = ign;
        c.fuel_cut_enable  = fuel;
        c.pair_rpm_mode    = pair;
        return c;
    endfunction

    task automatic send_tick(input logic [SENSOR_W-1:0] sensor, input logic [RPM_W-1:0] rpm);
        int gap;
        gap = quiet_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sensor_level <= sensor;
        s_engine_rpm   <= rpm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_tick(sensor, rpm);
    endtask

    task automatic send_release();
        send_tick(8'($urandom_range(8'h41, 8'hEF)), 16'($urandom_range(0, 16'hFFFF)));
    endtask

    // mostly low rpm so the kills stay short
    task automatic send_press();
        logic [RPM_W-1:0] rpm;
        if ($urandom_range(0, 9) < 6) rpm = 16'($urandom_range(16'h1401, 16'h1E00));
        else rpm = 16'($urandom_range(16'h1401, 16'hFFFF));
        send_tick(8'($urandom_range(0, SENSOR_PRESS_MAX)), rpm);
    endtask

    task automatic send_noise();
        send_tick(8'($urandom_range(0, 8'hFF)), 16'($urandom_range(0, 16'hFFFF)));
    endtask

    // stop sending until every tick has come out, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input cfg_t c);
        cfg_index_t           regs[7];
        logic [CFG_DATA_W-1:0] vals[7];
        regs = '{REG_REARM_DELAY, REG_MIN_ACTIVE_COUNT, REG_LOW_GEAR_RPM, REG_HIGH_GEAR_RPM,
                 REG_IGN_CUT_ENABLE, REG_FUEL_CUT_ENABLE, REG_PAIR_RPM_MODE};
        vals = '{c.rearm_delay, 16'(c.min_active_count), c.low_gear_rpm, c.high_gear_rpm,
                 16'(c.ign_cut_enable), 16'(c.fuel_cut_enable), 16'(c.pair_rpm_mode)};
        drain();
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            tracker.write_reg(regs[i], vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // release until rearmed, press until the kill arms, then ride it out when ride is set
    task automatic shift_sequence(input bit ride);
        int n;
        n = 0;
        while ((tracker.kill_active || tracker.kill_cnt != 0 || tracker.sixth_flag) && n < 600) begin
            send_release();
            n++;
        end
        repeat ($urandom_range(0, 2)) send_release();
        n = 0;
        while (!tracker.kill_active && n < int'(tracker.settings.min_active_count) + 3) begin
            if ($urandom_range(0, 19) == 0) begin
                send_tick(8'($urandom_range(0, SENSOR_PRESS_MAX)),
                          16'($urandom_range(0, RPM_PRESS_MIN)));
            end else begin
                send_press();
            end
            n++;
        end
        n = 0;
        while (ride && tracker.kill_active && n < 400) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_press();
                9:       send_noise();
                default: send_release();
            endcase
            n++;
        end
    endtask

    task automatic run_phase(input int unsigned budget, input bit noise_only);
        int unsigned start;
        int          r;
        start = tracker.n_ticks;
        // reload the sixth-gear hold with the new delay
        send_tick(8'($urandom_range(SENSOR_SIXTH_MIN, 8'hFF)), 16'($urandom_range(0, 16'hFFFF)));
        while (tracker.n_ticks - start < budget) begin
            quiet_gaps = ($urandom_range(0, 4) == 0);
            r = noise_only ? 80 : $urandom_range(0, 99);
            if (r < 70) begin
                shift_sequence(1'b1);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 15)) send_noise();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_tick(8'($urandom_range(SENSOR_SIXTH_MIN, 8'hFF)),
                              16'($urandom_range(0, 16'hFFFF)));
                end
                repeat ($urandom_range(1, 3)) send_press();
                shift_sequence(1'b1);
            end
            if ($urandom_range(0, 29) == 0) drain();
        end
        quiet_gaps = 1'b0;
    endtask

    // result side back-pressure
    initial begin
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 150)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_ready <= 1'b0;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge aclk);
                else repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            got.fuel_cut    = m_fuel_cut;
            got.ign_cut     = m_ign_cut;
            got.pair_action = pair_action_t'(m_pair_action);
            got.kill_on     = m_kill_on;
            tracker.check_output(got);
        end
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d ticks still pending", tracker.pending());
        $display("simulation failed");
        $finish;
    end

    initial begin
        tracker = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_sensor_level <= '0;
        s_engine_rpm   <= '0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= REG_REARM_DELAY;
        cfg_wdata      <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: boundary ticks, then one full rearm and kill
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_tick(DIR_SENSOR[i], DIR_RPM[i]);
        end
        shift_sequence(1'b0);

        // zero rearm and zero press requirement, thresholds at the bottom
        apply_settings(make_settings(16'd0, 8'd0, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1));
        run_phase(200, 1'b0);
        apply_settings(make_settings(16'd3, 8'd5, 16'h5000, 16'h6400, 1'b0, 1'b1, 1'b1));
        run_phase(250, 1'b0);
        // delays, counts and thresholds at the top, fuel cut off, PAIR left alone
        apply_settings(make_settings(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0));
        run_phase(80, 1'b1);
        apply_settings(make_settings(16'd10, 8'd2, 16'($urandom_range(0, 16'hFFFF)),
                                     16'($urandom_range(0, 16'hFFFF)), 1'b1, 1'b0, 1'b1));
        run_phase(200, 1'b0);
        // full press count, so the counter reaches its ceiling before a kill arms
        apply_settings(make_settings(16'd0, 8'hFF, 16'h4000, 16'h7000, 1'b1, 1'b1, 1'b1));
        run_phase(300, 1'b0);
        apply_settings(make_settings(16'($urandom_range(0, 20)), 8'($urandom_range(0, 8)),
                                     16'($urandom_range(0, 16'hFFFF)),
                                     16'($urandom_range(0, 16'hFFFF)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
        run_phase(200, 1'b0);

        drain();
        $display("%0d ticks sent under %0d register settings, %0d kills armed",
                 tracker.n_ticks, n_settings, tracker.n_kills);
        $display("%0d results checked, %0d mismatches", tracker.n_checked, tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
